// File: rtl/i2csfr_pkg.sv
// Package for the I2C sensor frame reader: bus phase codes, configuration
// register indexes and reset values. No dependencies.
package i2csfr_pkg;

    // Default number of bytes read back in one frame
    localparam int FRAME_BYTES_DEF = 5;

    // Number of frame bytes that feed the humidity and temperature fields
    localparam int FIELD_BYTES = 4;

    // Configuration register indexes and widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGISTER_ADDRESS = 2'd1;

    // Register reset values
    localparam logic [6:0] DEVICE_ADDRESS_RST   = 7'd92;
    localparam logic [7:0] REGISTER_ADDRESS_RST = 8'd0;

    // Number of data bits in one bus byte
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Bus sequencer phases
    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_START   = 8'b0000_0010,
        PH_WADDR   = 8'b0000_0100,
        PH_WREG    = 8'b0000_1000,
        PH_RESTART = 8'b0001_0000,
        PH_WRADDR  = 8'b0010_0000,
        PH_READ    = 8'b0100_0000,
        PH_STOP    = 8'b1000_0000
    } phase_t;

endpackage

// File: rtl/i2c_sensor_frame_reader.sv
// Each accepted tick beat gives a registered result beat in the next cycle.
// Throughput: one tick beat per cycle; the phase sequencer and the result
// register update together in a single pass, so only output stalls slow it.
// Reset (rst_n, asynchronous, active low): sequencer idle, counters and
// shifter cleared, device address 92, register address 0, no result pending.
// I2C master that reads one sensor frame, one bus tick per beat.
// Depends on i2csfr_pkg.
module i2c_sensor_frame_reader #(
    parameter int FRAME_BYTES = i2csfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [i2csfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2csfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    // tick input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               go,
    input  logic                               sda_in,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               scl_out,
    output logic                               sda_drive,
    output logic                               sda_out,
    output logic                               frame_done,
    output logic                               checksum_error,
    output logic                               ack_error,
    output logic [7:0]                         humidity_whole,
    output logic [7:0]                         humidity_tenths,
    output logic [7:0]                         temperature_whole,
    output logic [6:0]                         temperature_tenths,
    output logic                               temperature_negative
);

    localparam int BC_W = (FRAME_BYTES > 2) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [BC_W-1:0] LAST_BYTE = BC_W'(FRAME_BYTES - 1);
    localparam int FB = i2csfr_pkg::FIELD_BYTES;

    // Configuration registers
    logic [6:0] device_address_reg;
    logic [7:0] register_address_reg;

    // Sequencer state
    i2csfr_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      sub_step_reg, sub_step_next;
    logic [3:0]      bit_count_reg, bit_count_next;
    logic [BC_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]      shifter_reg, shifter_next;
    logic            nack_seen_reg, nack_seen_next;
    logic [7:0]      sum_reg, sum_next;
    logic            cks_err_reg, cks_err_next;

    // Frame bytes that feed the result fields
    logic [7:0]      frame_bytes_reg [FB];
    logic            fb_we;
    logic [1:0]      fb_idx;

    // Result register
    logic            out_valid_reg;
    logic            scl_reg, drv_reg, sda_reg, done_reg, cks_out_reg, ack_out_reg;
    logic [7:0]      hum_whole_reg, hum_tenths_reg, temp_whole_reg;
    logic [6:0]      temp_tenths_reg;
    logic            temp_neg_reg;

    logic            accept;
    logic            scl_c, drv_c, sda_c, done_c;
    logic [7:0]      rd_byte;
    logic            last_byte;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign rd_byte   = {shifter_reg[6:0], sda_in};
    assign last_byte = (byte_count_reg == LAST_BYTE);
    assign fb_idx    = 2'(byte_count_reg);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg   <= i2csfr_pkg::DEVICE_ADDRESS_RST;
            register_address_reg <= i2csfr_pkg::REGISTER_ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2csfr_pkg::CFG_DEVICE_ADDRESS:   device_address_reg   <= cfg_data[6:0];
                i2csfr_pkg::CFG_REGISTER_ADDRESS: register_address_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the bus sequencer by one tick
    always_comb
    begin
        phase_next      = phase_reg;
        sub_step_next   = sub_step_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        shifter_next    = shifter_reg;
        nack_seen_next  = nack_seen_reg;
        sum_next        = sum_reg;
        cks_err_next    = cks_err_reg;
        fb_we           = 1'b0;
        scl_c           = 1'b1;
        drv_c           = 1'b0;
        sda_c           = 1'b1;
        done_c          = 1'b0;

        case (phase_reg)
            i2csfr_pkg::PH_START, i2csfr_pkg::PH_RESTART:
            begin
                scl_c = (sub_step_reg == 2'd1) || (sub_step_reg == 2'd2);
                drv_c = 1'b1;
                sda_c = !sub_step_reg[1];
                if (sub_step_reg == 2'd3)
                begin
                    bit_count_next = 4'd0;
                    sub_step_next  = 2'd0;
                    if (phase_reg == i2csfr_pkg::PH_START)
                    begin
                        phase_next   = i2csfr_pkg::PH_WADDR;
                        shifter_next = {device_address_reg, 1'b0};
                    end
                    else
                    begin
                        phase_next   = i2csfr_pkg::PH_WRADDR;
                        shifter_next = {device_address_reg, 1'b1};
                    end
                end
                else
                begin
                    sub_step_next = sub_step_reg + 2'd1;
                end
            end

            i2csfr_pkg::PH_WADDR, i2csfr_pkg::PH_WREG, i2csfr_pkg::PH_WRADDR:
            begin
                scl_c = sub_step_reg[0];
                if (bit_count_reg < i2csfr_pkg::BITS_PER_BYTE)
                begin
                    // shift out one address or register bit
                    drv_c = 1'b1;
                    sda_c = shifter_reg[7];
                    if (sub_step_reg == 2'd1)
                    begin
                        shifter_next   = {shifter_reg[6:0], 1'b0};
                        bit_count_next = bit_count_reg + 4'd1;
                        sub_step_next  = 2'd0;
                    end
                    else
                    begin
                        sub_step_next = 2'd1;
                    end
                end
                else
                begin
                    // release the line and sample the slave acknowledge
                    if (sub_step_reg == 2'd1)
                    begin
                        nack_seen_next = nack_seen_reg | sda_in;
                        sub_step_next  = 2'd0;
                        bit_count_next = 4'd0;
                        case (phase_reg)
                            i2csfr_pkg::PH_WADDR:
                            begin
                                phase_next   = i2csfr_pkg::PH_WREG;
                                shifter_next = register_address_reg;
                            end
                            i2csfr_pkg::PH_WREG:
                            begin
                                phase_next = i2csfr_pkg::PH_RESTART;
                            end
                            default:
                            begin
                                phase_next      = i2csfr_pkg::PH_READ;
                                byte_count_next = '0;
                                shifter_next    = 8'd0;
                                sum_next        = 8'd0;
                            end
                        endcase
                    end
                    else
                    begin
                        sub_step_next = 2'd1;
                    end
                end
            end

            i2csfr_pkg::PH_READ:
            begin
                scl_c = sub_step_reg[0];
                if (bit_count_reg < i2csfr_pkg::BITS_PER_BYTE)
                begin
                    // shift in one data bit; store the byte and fold the checksum
                    if (sub_step_reg == 2'd1)
                    begin
                        shifter_next   = rd_byte;
                        bit_count_next = bit_count_reg + 4'd1;
                        sub_step_next  = 2'd0;
                        if (bit_count_reg == i2csfr_pkg::BITS_PER_BYTE - 4'd1)
                        begin
                            fb_we = (32'(byte_count_reg) < FB);
                            if (last_byte)
                            begin
                                cks_err_next = (sum_reg != rd_byte);
                            end
                            else
                            begin
                                sum_next = sum_reg + rd_byte;
                            end
                        end
                    end
                    else
                    begin
                        sub_step_next = 2'd1;
                    end
                end
                else
                begin
                    // acknowledge every byte but the last, which gets a NACK
                    drv_c = 1'b1;
                    sda_c = last_byte;
                    if (sub_step_reg == 2'd1)
                    begin
                        bit_count_next = 4'd0;
                        sub_step_next  = 2'd0;
                        shifter_next   = 8'd0;
                        if (last_byte)
                        begin
                            phase_next = i2csfr_pkg::PH_STOP;
                        end
                        else
                        begin
                            byte_count_next = byte_count_reg + BC_W'(1);
                        end
                    end
                    else
                    begin
                        sub_step_next = 2'd1;
                    end
                end
            end

            i2csfr_pkg::PH_STOP:
            begin
                drv_c = 1'b1;
                if (sub_step_reg == 2'd0)
                begin
                    scl_c         = 1'b0;
                    sda_c         = 1'b0;
                    sub_step_next = 2'd1;
                end
                else if (sub_step_reg == 2'd1)
                begin
                    sda_c         = 1'b0;
                    sub_step_next = 2'd2;
                end
                else
                begin
                    done_c        = 1'b1;
                    phase_next    = i2csfr_pkg::PH_IDLE;
                    sub_step_next = 2'd0;
                end
            end

            default:
            begin
                // idle: hold the bus released and wait for go
                phase_next = i2csfr_pkg::PH_IDLE;
                if (go)
                begin
                    phase_next      = i2csfr_pkg::PH_START;
                    sub_step_next   = 2'd0;
                    bit_count_next  = 4'd0;
                    byte_count_next = '0;
                    shifter_next    = 8'd0;
                    nack_seen_next  = 1'b0;
                    sum_next        = 8'd0;
                    cks_err_next    = 1'b0;
                end
            end
        endcase
    end

    // Update sequencer state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2csfr_pkg::PH_IDLE;
            sub_step_reg   <= 2'd0;
            bit_count_reg  <= 4'd0;
            byte_count_reg <= '0;
            shifter_reg    <= 8'd0;
            nack_seen_reg  <= 1'b0;
            sum_reg        <= 8'd0;
            cks_err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            sub_step_reg   <= sub_step_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            shifter_reg    <= shifter_next;
            nack_seen_reg  <= nack_seen_next;
            sum_reg        <= sum_next;
            cks_err_reg    <= cks_err_next;
        end
    end

    // Store frame bytes
    always_ff @(posedge clk)
    begin
        if (accept && fb_we)
        begin
            frame_bytes_reg[fb_idx] <= rd_byte;
        end
    end

    // Hold the result valid flag until the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_reg         <= scl_c;
            drv_reg         <= drv_c;
            sda_reg         <= sda_c;
            done_reg        <= done_c;
            cks_out_reg     <= done_c && cks_err_reg;
            ack_out_reg     <= done_c && nack_seen_reg;
            hum_whole_reg   <= done_c ? frame_bytes_reg[0] : 8'd0;
            hum_tenths_reg  <= (done_c && (FRAME_BYTES > 1)) ? frame_bytes_reg[1] : 8'd0;
            temp_whole_reg  <= (done_c && (FRAME_BYTES > 2)) ? frame_bytes_reg[2] : 8'd0;
            temp_tenths_reg <= (done_c && (FRAME_BYTES > 3)) ? frame_bytes_reg[3][6:0] : 7'd0;
            temp_neg_reg    <= done_c && (FRAME_BYTES > 3) && frame_bytes_reg[3][7];
        end
    end

    assign out_valid            = out_valid_reg;
    assign scl_out              = scl_reg;
    assign sda_drive            = drv_reg;
    assign sda_out              = sda_reg;
    assign frame_done           = done_reg;
    assign checksum_error       = cks_out_reg;
    assign ack_error            = ack_out_reg;
    assign humidity_whole       = hum_whole_reg;
    assign humidity_tenths      = hum_tenths_reg;
    assign temperature_whole    = temp_whole_reg;
    assign temperature_tenths   = temp_tenths_reg;
    assign temperature_negative = temp_neg_reg;

    // A finished frame ends with the stop condition on the bus
    a_done_lines: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> scl_reg && drv_reg && sda_reg)
        else $error("frame_done without stop levels on the bus");

    // The last stop tick yields a frame_done beat
    a_stop_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == i2csfr_pkg::PH_STOP) && sub_step_reg[1]
        |=> out_valid_reg && done_reg && (phase_reg == i2csfr_pkg::PH_IDLE))
        else $error("stop completed without frame_done");

    // Bit phases alternate between two sub-steps and count at most one byte
    a_bit_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2csfr_pkg::PH_WADDR) || (phase_reg == i2csfr_pkg::PH_WREG) ||
        (phase_reg == i2csfr_pkg::PH_WRADDR) || (phase_reg == i2csfr_pkg::PH_READ)
        |-> !sub_step_reg[1] && (bit_count_reg <= i2csfr_pkg::BITS_PER_BYTE))
        else $error("bit sequencer counters out of range");

endmodule
